// ----- rtl/brush_canvas_painter_unit_assert.svh -----
// Assertion macros shared by the painter's checker.
`ifndef BRUSH_CANVAS_PAINTER_UNIT_ASSERT_SVH
`define BRUSH_CANVAS_PAINTER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define BCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define BCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bcp_pkg.sv -----
// Types, codes, constants and microcode for the brush canvas painter.
package bcp_pkg;

  localparam int DIM_W  = 9;   // canvas dimension in use
  localparam int CRD_W  = 10;  // canvas row and column counters
  localparam int PROD_W = 19;  // row * width, width * height

  localparam logic [23:0] WHITE_RGB = 24'hFF_FFFF;

  // Operation codes
  localparam logic [2:0] OP_PRESS   = 3'd0;
  localparam logic [2:0] OP_RELEASE = 3'd1;
  localparam logic [2:0] OP_MOVE    = 3'd2;
  localparam logic [2:0] OP_REPLACE = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  // Channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd2;
  localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd3;
  localparam logic [2:0] REG_BRUSH_SIZE    = 3'd4;
  localparam logic [2:0] REG_PEN_COLOR     = 3'd5;

  localparam logic [8:0] CANVAS_DIM_RST = 9'd256;
  localparam logic [5:0] BRUSH_SIZE_RST = 6'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [11:0] x;
    logic [11:0] y;
    logic [1:0]  channel;
    logic [7:0]  from_value;
    logic [7:0]  to_value;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [23:0] pixel;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLR      = 4'd0,
    S_IDLE     = 4'd1,
    S_ST_ROW   = 4'd2,
    S_ST_COL   = 4'd3,
    S_ST_NEXT  = 4'd4,
    S_DONE     = 4'd5,
    S_RP_AREA  = 4'd6,
    S_RP_LOOP  = 4'd7,
    S_RP_DRAIN = 4'd8,
    S_RD_MUL   = 4'd9,
    S_RD_ISSUE = 4'd10,
    S_RD_WAIT  = 4'd11
  } step_t;

  typedef enum logic [1:0] {MUL_NONE, MUL_ROW, MUL_AREA} mul_sel_t;
  typedef enum logic       {ROW_HOLD, ROW_INC} row_op_t;
  typedef enum logic [1:0] {COL_HOLD, COL_LOAD_BX, COL_INC} col_op_t;
  typedef enum logic [1:0] {IDX_HOLD, IDX_CLEAR, IDX_INC} idx_op_t;
  typedef enum logic [2:0] {
    MEM_NONE, MEM_CLR_WR, MEM_STAMP_WR, MEM_RPL_RD, MEM_PIX_RD
  } mem_op_t;
  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_CLR_MORE, C_ROW_END, C_COL_MORE, C_CH_BAD, C_IDX_MORE, C_RD_BAD
  } cond_t;

  typedef struct packed {
    mul_sel_t mul;
    row_op_t  row;
    col_op_t  col;
    idx_op_t  idx;
    mem_op_t  mem;
    cond_t    cond;
    step_t    target;
    logic     cap;
    logic     fin;
  } uword_t;

  localparam uword_t UW_NOP = '{
    mul: MUL_NONE, row: ROW_HOLD, col: COL_HOLD, idx: IDX_HOLD, mem: MEM_NONE,
    cond: C_NEVER, target: S_IDLE, cap: 1'b0, fin: 1'b0
  };

  // Control store: one word per step, jump to target when cond holds.
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = UW_NOP;
    unique case (s)
      S_CLR: begin
        w.mem = MEM_CLR_WR; w.idx = IDX_INC; w.cond = C_CLR_MORE; w.target = S_CLR;
      end
      S_IDLE: begin
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_ST_ROW: begin
        w.mul = MUL_ROW; w.col = COL_LOAD_BX; w.cond = C_ROW_END; w.target = S_DONE;
      end
      S_ST_COL: begin
        w.mem = MEM_STAMP_WR; w.col = COL_INC; w.cond = C_COL_MORE; w.target = S_ST_COL;
      end
      S_ST_NEXT: begin
        w.row = ROW_INC; w.cond = C_ALWAYS; w.target = S_ST_ROW;
      end
      S_DONE: begin
        w.fin = 1'b1; w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_RP_AREA: begin
        w.mul = MUL_AREA; w.idx = IDX_CLEAR; w.cond = C_CH_BAD; w.target = S_DONE;
      end
      S_RP_LOOP: begin
        w.mem = MEM_RPL_RD; w.idx = IDX_INC; w.cond = C_IDX_MORE; w.target = S_RP_LOOP;
      end
      S_RP_DRAIN: begin
        w.cond = C_ALWAYS; w.target = S_DONE;
      end
      S_RD_MUL: begin
        w.mul = MUL_ROW; w.cond = C_RD_BAD; w.target = S_DONE;
      end
      S_RD_ISSUE: begin
        w.mem = MEM_PIX_RD;
      end
      S_RD_WAIT: begin
        w.cap = 1'b1; w.cond = C_ALWAYS; w.target = S_DONE;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/bcp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bcp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ----- rtl/brush_canvas_painter_unit.sv -----
// Top level of the brush canvas painter: microcoded sequencer, datapath and frame store.
//
// Usage: drive in_item and raise start; the item is taken at a clock edge where start
// is high and busy is low. Each item yields one result on out_item, shown for exactly
// one cycle with out_valid high; the receiver cannot stall it. Registers are written
// through cfg_valid / cfg_index / cfg_data (cfg_ready is always high); the user must
// write them only while idle, which the block itself does not enforce. The step program
// works over one frame store port: press/release/move without stamp go straight to the
// result; a stamp walks R rows and C columns of the clipped square; a read forms the
// row base, issues the read and captures the pixel, skipping both when the point is off
// the canvas; a channel replace walks W * H pixels, one pixel per cycle through read and
// write-back, and skips the walk for channel code three.
// After reset the block walks the whole store, MAX_WIDTH * MAX_HEIGHT words, writing
// white; busy stays high during that pass, configuration writes are still taken.
// busy drops in the cycle that out_valid is shown, so a new item may enter then.
module brush_canvas_painter_unit import bcp_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (AW + 1 > PROD_W + 1) ? AW + 1 : PROD_W + 1;
  localparam logic [12:0] MAX_W13 = 13'(MAX_WIDTH);
  localparam logic [12:0] MAX_H13 = 13'(MAX_HEIGHT);
  localparam logic [AW:0] LAST_IDX = (AW + 1)'(DEPTH - 1);

  // Configuration
  logic [11:0] ox_r, oy_r;
  logic [8:0]  cwid_r, chgt_r;
  logic [5:0]  bsize_r;
  logic [23:0] pen_r;

  // Sequencer and control state
  step_t       pc_r, pc_nxt, disp;
  uword_t      uw;
  logic        cond_ok;
  logic        pen_down_r;
  logic [23:0] stroke_r;
  logic        out_valid_r;
  logic        wb_vld_r;
  logic [AW:0] idx_r;

  // Datapath
  logic [CRD_W-1:0]  row_r, col_r, bx_r, ex_r, ey_r;
  logic [PROD_W-1:0] prod_r, mul_p;
  logic [CRD_W-1:0]  mul_a;
  logic              hit_r, rd_ok_r;
  logic [23:0]       pix_r;
  logic [1:0]        chan_r;
  logic [7:0]        from_r, to_r;
  logic [AW-1:0]     wb_addr_r;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [12:0]      x_end, y_end;
  logic [11:0]      rx, ry;
  logic [CRD_W-1:0] rx_c, ry_c, p10, bx_c, by_c, ex_c, ey_c;
  logic [CRD_W:0]   sx, sy;
  logic             hit_c, is_ptr, rd_ok_c, accept;
  logic [XW-1:0]    pt_sum, idx_x, prod_x;

  // Frame store port signals
  logic          stamp_go, rpl_go, wb_hit;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [23:0]   wr_data, rd_data, wb_data;
  logic [7:0]    wb_byte;

  assign uw        = ucode(pc_r);
  assign busy      = (pc_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = '{hit: hit_r, pixel: pix_r};

  // Dimensions in use, capped at the store size
  assign w_eff = ({4'd0, cwid_r} > MAX_W13) ? MAX_W13[DIM_W-1:0] : cwid_r;
  assign h_eff = ({4'd0, chgt_r} > MAX_H13) ? MAX_H13[DIM_W-1:0] : chgt_r;

  // Hit test: right edge exclusive, bottom edge inclusive
  assign x_end  = {1'b0, ox_r} + {4'd0, w_eff};
  assign y_end  = {1'b0, oy_r} + {4'd0, h_eff};
  assign hit_c  = (in_item.x >= ox_r) && ({1'b0, in_item.x} < x_end) &&
                  (in_item.y >= oy_r) && ({1'b0, in_item.y} <= y_end);
  assign is_ptr = (in_item.op == OP_PRESS) || (in_item.op == OP_RELEASE) ||
                  (in_item.op == OP_MOVE);
  assign rd_ok_c = (in_item.x < {3'd0, w_eff}) && (in_item.y < {3'd0, h_eff});

  // Stamp span; offsets are only used on a hit, where they fit the canvas
  assign rx   = in_item.x - ox_r;
  assign ry   = in_item.y - oy_r;
  assign rx_c = rx[CRD_W-1:0];
  assign ry_c = ry[CRD_W-1:0];
  assign p10  = CRD_W'(bsize_r[5:1]);
  assign bx_c = (rx_c > p10) ? rx_c - p10 : rx_c;
  assign by_c = (ry_c > p10) ? ry_c - p10 : ry_c;
  assign sx   = {1'b0, rx_c} + {1'b0, p10};
  assign sy   = {1'b0, ry_c} + {1'b0, p10};
  assign ex_c = (sx < {2'd0, w_eff}) ? sx[CRD_W-1:0] : rx_c;
  assign ey_c = (sy < {2'd0, h_eff}) ? sy[CRD_W-1:0] : ry_c;

  always_comb begin
    case (in_item.op)
      OP_PRESS:   disp = hit_c ? S_ST_ROW : S_DONE;
      OP_MOVE:    disp = (hit_c && pen_down_r) ? S_ST_ROW : S_DONE;
      OP_REPLACE: disp = S_RP_AREA;
      OP_READ:    disp = S_RD_MUL;
      default:    disp = S_DONE;
    endcase
  end

  assign pt_sum = XW'(prod_r) + XW'(col_r);
  assign idx_x  = XW'(idx_r);
  assign prod_x = XW'(prod_r);

  always_comb begin
    case (uw.cond)
      C_ALWAYS:   cond_ok = 1'b1;
      C_CLR_MORE: cond_ok = (idx_r != LAST_IDX);
      C_ROW_END:  cond_ok = (row_r >= ey_r);
      C_COL_MORE: cond_ok = (({1'b0, col_r} + 1'b1) < {1'b0, ex_r});
      C_CH_BAD:   cond_ok = (chan_r != CH_RED) && (chan_r != CH_GREEN) &&
                            (chan_r != CH_BLUE);
      C_IDX_MORE: cond_ok = ((idx_x + 1'b1) < prod_x);
      C_RD_BAD:   cond_ok = !rd_ok_r;
      default:    cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    if (pc_r == S_IDLE && start) begin
      pc_nxt = disp;
    end else if (cond_ok) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = step_t'(pc_r + 4'd1);
    end
  end

  // Shared multiplier: row base or canvas area
  assign mul_a = (uw.mul == MUL_AREA) ? {1'b0, h_eff} : row_r;
  assign mul_p = mul_a * w_eff;

  // Frame store access
  assign stamp_go = (uw.mem == MEM_STAMP_WR) && (col_r < ex_r);
  assign rpl_go   = (uw.mem == MEM_RPL_RD) && (idx_x < prod_x);

  always_comb begin
    case (chan_r)
      CH_RED:   wb_byte = rd_data[23:16];
      CH_GREEN: wb_byte = rd_data[15:8];
      default:  wb_byte = rd_data[7:0];
    endcase
    wb_data = rd_data;
    case (chan_r)
      CH_RED:   wb_data[23:16] = to_r;
      CH_GREEN: wb_data[15:8]  = to_r;
      default:  wb_data[7:0]   = to_r;
    endcase
  end

  assign wb_hit = wb_vld_r && (wb_byte == from_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pt_sum[AW-1:0];
    wr_data = stroke_r;
    if (wb_hit) begin
      wr_en   = 1'b1;
      wr_addr = wb_addr_r;
      wr_data = wb_data;
    end else if (uw.mem == MEM_CLR_WR) begin
      wr_en   = 1'b1;
      wr_addr = idx_r[AW-1:0];
      wr_data = WHITE_RGB;
    end else if (stamp_go) begin
      wr_en   = 1'b1;
    end
  end

  assign rd_en   = rpl_go || (uw.mem == MEM_PIX_RD);
  assign rd_addr = rpl_go ? idx_r[AW-1:0] : pt_sum[AW-1:0];

  bcp_ram #(
    .WIDTH(24),
    .DEPTH(DEPTH)
  ) u_frame (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_CLR;
      pen_down_r  <= 1'b0;
      stroke_r    <= '0;
      out_valid_r <= 1'b0;
      wb_vld_r    <= 1'b0;
      idx_r       <= '0;
      ox_r        <= '0;
      oy_r        <= '0;
      cwid_r      <= CANVAS_DIM_RST;
      chgt_r      <= CANVAS_DIM_RST;
      bsize_r     <= BRUSH_SIZE_RST;
      pen_r       <= '0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= uw.fin;
      wb_vld_r    <= rpl_go;
      case (uw.idx)
        IDX_CLEAR: idx_r <= '0;
        IDX_INC:   idx_r <= idx_r + 1'b1;
        default:   idx_r <= idx_r;
      endcase
      if (accept) begin
        if (in_item.op == OP_PRESS && hit_c) begin
          stroke_r   <= pen_r;
          pen_down_r <= 1'b1;
        end else if (in_item.op == OP_RELEASE && hit_c) begin
          stroke_r   <= pen_r;
          pen_down_r <= 1'b0;
        end else if (in_item.op == OP_MOVE && !hit_c) begin
          pen_down_r <= 1'b0;
        end
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ORIGIN_X:      ox_r    <= cfg_data[11:0];
          REG_ORIGIN_Y:      oy_r    <= cfg_data[11:0];
          REG_CANVAS_WIDTH:  cwid_r  <= cfg_data[8:0];
          REG_CANVAS_HEIGHT: chgt_r  <= cfg_data[8:0];
          REG_BRUSH_SIZE:    bsize_r <= cfg_data[5:0];
          REG_PEN_COLOR:     pen_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r   <= (in_item.op == OP_READ) ? in_item.y[CRD_W-1:0] : by_c;
      col_r   <= in_item.x[CRD_W-1:0];
      bx_r    <= bx_c;
      ex_r    <= ex_c;
      ey_r    <= ey_c;
      hit_r   <= is_ptr ? hit_c : 1'b1;
      pix_r   <= '0;
      rd_ok_r <= rd_ok_c;
      chan_r  <= in_item.channel;
      from_r  <= in_item.from_value;
      to_r    <= in_item.to_value;
    end else begin
      if (uw.row == ROW_INC) begin
        row_r <= row_r + 1'b1;
      end
      case (uw.col)
        COL_LOAD_BX: col_r <= bx_r;
        COL_INC:     col_r <= col_r + 1'b1;
        default:     col_r <= col_r;
      endcase
      if (uw.cap) begin
        pix_r <= rd_data;
      end
    end
    if (uw.mul != MUL_NONE) begin
      prod_r <= mul_p;
    end
    // Write back in the cycle after the replace read
    wb_addr_r <= idx_r[AW-1:0];
  end

endmodule

// ----- rtl/bcp_checker.sv -----
// Port-level checks on the painter's result strobe and busy handshake.
`include "brush_canvas_painter_unit_assert.svh"

module bcp_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  `BCP_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held two cycles")
  `BCP_ASSERT_NOW(a_result_when_idle, out_valid, !busy, "result shown while still busy")
  `BCP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item left block idle")

endmodule

bind brush_canvas_painter_unit bcp_checker u_bcp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid)
);

// ----- tb/tb_brush_canvas_painter_unit.sv -----
// Self-checking testbench for the brush canvas painter: queued items, shadow frame store.
`timescale 1ns / 1ps

module tb_brush_canvas_painter_unit;
  import bcp_pkg::*;

  localparam int FRAME_W = 256;
  localparam int FRAME_H = 256;
  localparam int FRAME_DEPTH = FRAME_W * FRAME_H;
  localparam int QUIET_LIMIT = 200000;
  localparam int TAIL_CYCLES = 16;

  // Codes the block does not define
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [1:0] CH_NONE = 2'd3;
  localparam logic [2:0] REG_UNUSED_LO = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic     wait_idle;
    in_item_t item;
  } queued_op_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  // Shadow of the block's registers and state
  logic [11:0] reg_origin_x = '0;
  logic [11:0] reg_origin_y = '0;
  logic [8:0]  reg_canvas_w = CANVAS_DIM_RST;
  logic [8:0]  reg_canvas_h = CANVAS_DIM_RST;
  logic [5:0]  reg_brush = BRUSH_SIZE_RST;
  logic [23:0] reg_pen = '0;
  logic [23:0] canvas_mem [FRAME_DEPTH];
  logic        pen_is_down = 1'b0;
  logic [23:0] stroke_rgb = '0;

  queued_op_t op_backlog[$];
  out_item_t  answer_q[$];
  int         gap_left = 0;
  int         gap_pct = 0;
  int         err_count = 0;
  int         quiet_cycles = 0;
  logic       hold_next = 1'b0;
  int         gen_ox, gen_oy, gen_w, gen_h, gen_brush, gen_pen;

  brush_canvas_painter_unit #(
    .MAX_WIDTH (FRAME_W),
    .MAX_HEIGHT(FRAME_H)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Uniform pick in [lo, hi]; offset so negative bounds work.
  function automatic int rnd(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic int clamp12(input int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  // Paint the clipped square around canvas point (rx, ry).
  function automatic void stamp_brush(input int rx, input int ry, input int w, input int h);
    int reach, bx, by, ex, ey, r, c;
    reach = int'(reg_brush) >> 1;
    bx = (rx > reach) ? rx - reach : rx;
    by = (ry > reach) ? ry - reach : ry;
    ex = (rx + reach < w) ? rx + reach : rx;
    ey = (ry + reach < h) ? ry + reach : ry;
    for (r = by; r < ey; r++)
      for (c = bx; c < ex; c++)
        if (r * w + c < FRAME_DEPTH) canvas_mem[r * w + c] = stroke_rgb;
  endfunction

  // Apply one item to the shadow state and return the answer it must produce.
  function automatic out_item_t paint_and_answer(input in_item_t it);
    out_item_t   res;
    int          w, h, ox, oy, ix, iy, shift, i;
    logic        on_canvas;
    logic [23:0] px;
    w = (int'(reg_canvas_w) > FRAME_W) ? FRAME_W : int'(reg_canvas_w);
    h = (int'(reg_canvas_h) > FRAME_H) ? FRAME_H : int'(reg_canvas_h);
    ox = int'(reg_origin_x);
    oy = int'(reg_origin_y);
    ix = int'(it.x);
    iy = int'(it.y);
    res.hit = 1'b1;
    res.pixel = '0;
    // bottom edge counts as inside
    on_canvas = (ix >= ox) && (ix < ox + w) && (iy >= oy) && (iy <= oy + h);
    case (it.op)
      OP_PRESS: begin
        res.hit = on_canvas;
        if (on_canvas) begin
          stroke_rgb = reg_pen;
          pen_is_down = 1'b1;
          stamp_brush(ix - ox, iy - oy, w, h);
        end
      end
      OP_RELEASE: begin
        res.hit = on_canvas;
        if (on_canvas) begin
          stroke_rgb = reg_pen;
          pen_is_down = 1'b0;
        end
      end
      OP_MOVE: begin
        res.hit = on_canvas;
        if (!on_canvas) pen_is_down = 1'b0;
        else if (pen_is_down) stamp_brush(ix - ox, iy - oy, w, h);
      end
      OP_REPLACE: begin
        if (it.channel <= CH_BLUE) begin
          shift = (it.channel == CH_RED) ? 16 : (it.channel == CH_GREEN) ? 8 : 0;
          for (i = 0; i < w * h && i < FRAME_DEPTH; i++) begin
            px = canvas_mem[i];
            if (8'(px >> shift) == it.from_value)
              canvas_mem[i] = (px & ~(24'hFF << shift)) | (24'(it.to_value) << shift);
          end
        end
      end
      OP_READ: begin
        if (ix < w && iy < h && iy * w + ix < FRAME_DEPTH) res.pixel = canvas_mem[iy * w + ix];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Driver: present queued items, predict each one as it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (!start || !busy) begin
      if (start) answer_q.push_back(paint_and_answer(in_item));
      if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (op_backlog.size() == 0 ||
                   (op_backlog[0].wait_idle && answer_q.size() != 0)) begin
        start <= 1'b0;
      end else if (rnd(1, 100) <= gap_pct) begin
        start <= 1'b0;
        gap_left <= rnd(0, 3);
      end else begin
        in_item <= op_backlog[0].item;
        op_backlog.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Monitor: every strobed result against the oldest answer.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: hit %0b pixel %06h", out_item.hit, out_item.pixel);
      end else begin
        want = answer_q.pop_front();
        if (out_item.hit !== want.hit || out_item.pixel !== want.pixel) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: hit exp %0b got %0b, pixel exp %06h got %06h",
                     want.hit, out_item.hit, want.pixel, out_item.pixel);
        end
      end
    end
  end

  // Register shadow follows the write channel.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X:      reg_origin_x <= cfg_data[11:0];
        REG_ORIGIN_Y:      reg_origin_y <= cfg_data[11:0];
        REG_CANVAS_WIDTH:  reg_canvas_w <= cfg_data[8:0];
        REG_CANVAS_HEIGHT: reg_canvas_h <= cfg_data[8:0];
        REG_BRUSH_SIZE:    reg_brush <= cfg_data[5:0];
        REG_PEN_COLOR:     reg_pen <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Watchdog on cycles with no handshake of any kind.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input int val, input int bits);
    logic [23:0] data;
    data = 24'(val);
    // junk above the register width must be dropped
    if (bits < 24 && rnd(0, 1) == 1) data = data | (24'($urandom) << bits);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_canvas(input int ox, input int oy, input int w, input int h,
                                input int brush, input int pen);
    gen_ox = ox;
    gen_oy = oy;
    gen_w = (w > FRAME_W) ? FRAME_W : w;
    gen_h = (h > FRAME_H) ? FRAME_H : h;
    gen_brush = brush;
    gen_pen = pen;
    write_reg(REG_ORIGIN_X, ox, 12);
    write_reg(REG_ORIGIN_Y, oy, 12);
    write_reg(REG_CANVAS_WIDTH, w, 9);
    write_reg(REG_CANVAS_HEIGHT, h, 9);
    write_reg(REG_BRUSH_SIZE, brush, 6);
    write_reg(REG_PEN_COLOR, pen, 24);
  endtask

  task automatic queue_item(input logic [2:0] op, input int x, input int y,
                            input logic [1:0] ch = CH_RED, input int from = 0,
                            input int to = 0);
    queued_op_t q;
    q.wait_idle = hold_next;
    q.item.op = op;
    q.item.x = 12'(x);
    q.item.y = 12'(y);
    q.item.channel = ch;
    q.item.from_value = 8'(from);
    q.item.to_value = 8'(to);
    op_backlog.push_back(q);
    hold_next = 1'b0;
  endtask

  task automatic wait_drained();
    while (op_backlog.size() != 0 || start || answer_q.size() != 0) @(negedge clk);
  endtask

  // Screen coordinate near a canvas span, edges included, now and then anywhere.
  function automatic int near_span(input int org, input int span);
    if (rnd(0, 7) == 0) return rnd(0, 4095);
    return clamp12(org - 1 + rnd(0, span + 2));
  endfunction

  task automatic queue_random_phase(input int n_items);
    int made, k, cx, cy, reach, area;
    logic [1:0] ch;
    made = 0;
    reach = gen_brush >> 1;
    area = gen_w * gen_h;
    while (made < n_items) begin
      case (rnd(0, 9))
        0, 1, 2, 3, 4: begin
          cx = near_span(gen_ox, gen_w);
          cy = near_span(gen_oy, gen_h);
          queue_item(OP_PRESS, cx, cy);
          k = rnd(1, 4);
          repeat (k) begin
            if (rnd(0, 5) == 0) begin
              cx = near_span(gen_ox, gen_w);
              cy = near_span(gen_oy, gen_h);
            end else begin
              cx = clamp12(cx + rnd(-2, 2));
              cy = clamp12(cy + rnd(-2, 2));
            end
            queue_item(OP_MOVE, cx, cy);
          end
          queue_item(OP_RELEASE, cx, cy);
          // look at the painted area, sometimes only once the block is idle
          hold_next = (rnd(0, 3) == 0);
          queue_item(OP_READ, clamp12(cx - gen_ox + rnd(-reach - 1, reach + 1)),
                     clamp12(cy - gen_oy + rnd(-reach - 1, reach + 1)));
          made += k + 3;
        end
        5, 6: begin
          if (rnd(0, 9) == 0) queue_item(OP_READ, rnd(0, 4095), rnd(0, 4095));
          else queue_item(OP_READ, rnd(0, gen_w), rnd(0, gen_h));
          made++;
        end
        7: begin
          ch = 2'(rnd(0, 3));
          // keep full walks of the store rare
          if (area > 4096) ch = CH_NONE;
          case (rnd(0, 2))
            0: queue_item(OP_REPLACE, rnd(0, 4095), rnd(0, 4095), ch, 255, rnd(0, 255));
            1: queue_item(OP_REPLACE, rnd(0, 4095), rnd(0, 4095), ch,
                          (ch == CH_NONE) ? 0 : int'(8'(gen_pen >> (16 - 8 * ch))),
                          rnd(0, 255));
            default: queue_item(OP_REPLACE, rnd(0, 4095), rnd(0, 4095), ch, rnd(0, 255),
                                rnd(0, 255));
          endcase
          made++;
        end
        default: begin
          queue_item(3'(rnd(0, 7)), rnd(0, 4095), rnd(0, 4095), 2'(rnd(0, 3)), rnd(0, 255),
                     rnd(0, 255));
          made++;
        end
      endcase
    end
  endtask

  function automatic int pick_dim();
    int r;
    r = rnd(0, 9);
    if (r < 7) return rnd(1, 24);
    if (r < 9) return rnd(25, 300);
    return rnd(301, 511);
  endfunction

  initial begin
    int ph, w, h;
    foreach (canvas_mem[i]) canvas_mem[i] = WHITE_RGB;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    gap_pct = 25;

    // Full canvas at the screen origin; written while the store clears.
    program_canvas(0, 0, 256, 256, 5, 24'h00FF00);
    write_reg(REG_UNUSED_LO, 24'hFFFFFF, 24);
    write_reg(REG_UNUSED_HI, 24'h5A5A5A, 24);
    queue_item(OP_READ, 0, 0);
    queue_item(OP_READ, 255, 255);
    queue_item(OP_READ, 256, 0);
    queue_item(OP_READ, 4095, 4095);
    queue_item(OP_MOVE, 10, 10);
    queue_item(OP_PRESS, 10, 10);
    queue_item(OP_READ, 8, 8);
    queue_item(OP_READ, 12, 12);
    queue_item(OP_MOVE, 0, 0);
    queue_item(OP_READ, 0, 0);
    queue_item(OP_MOVE, 4095, 4095);
    queue_item(OP_MOVE, 20, 20);
    queue_item(OP_RELEASE, 255, 256);
    queue_item(OP_PRESS, 255, 256);
    queue_item(OP_REPLACE, 0, 0, CH_RED, 255, 0);
    hold_next = 1'b1;
    queue_item(OP_READ, 254, 255);
    queue_item(OP_REPLACE, 0, 0, CH_NONE, 0, 255);
    queue_item(OP_SPARE_LO, 4095, 4095, CH_NONE, 255, 255);
    queue_item(OP_SPARE_HI, 0, 0);
    wait_drained();

    // Corner origin, oversized canvas, widest brush.
    program_canvas(4095, 4095, 511, 511, 63, 24'hFFFFFF);
    queue_item(OP_PRESS, 4095, 4095);
    queue_item(OP_READ, 30, 30);
    queue_item(OP_RELEASE, 0, 0);
    wait_drained();

    // Zero width.
    program_canvas(4095, 0, 0, 1, 0, 0);
    queue_item(OP_PRESS, 4095, 0);
    queue_item(OP_READ, 0, 0);
    wait_drained();

    // Zero height.
    program_canvas(100, 100, 1, 0, 0, 24'hABCDEF);
    queue_item(OP_PRESS, 100, 100);
    queue_item(OP_REPLACE, 0, 0, CH_GREEN, 255, 0);
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      gap_pct = (ph == 2 || ph == 5) ? 0 : rnd(10, 40);
      w = pick_dim();
      h = pick_dim();
      program_canvas(rnd(0, 4095), rnd(0, 4095), w, h,
                     (rnd(0, 9) < 8) ? rnd(0, 12) : rnd(13, 63), int'($urandom & 24'hFFFFFF));
      queue_random_phase(12);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
